### sv/cchs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchs_pkg
// Shared types and codes for the connection close handshake block.
// ----------------------------------------------------------------------------
package cchs_pkg;

  // Per-connection handshake state code
  typedef logic [2:0] cstate_t;

  localparam cstate_t ST_INACTIVE = 3'd0;
  localparam cstate_t ST_ACTIVE   = 3'd1;
  localparam cstate_t ST_LOCAL    = 3'd2;
  localparam cstate_t ST_REMOTE   = 3'd3;
  localparam cstate_t ST_ACKED    = 3'd4;
  localparam cstate_t ST_CLOSED   = 3'd5;
  localparam cstate_t ST_MORIBUND = 3'd6;

  // Command codes
  typedef logic [1:0] cmd_code_t;

  localparam cmd_code_t CMD_CLOSE    = 2'd0;
  localparam cmd_code_t CMD_PACKET   = 2'd1;
  localparam cmd_code_t CMD_TERM     = 2'd2;
  localparam cmd_code_t CMD_ACTIVATE = 2'd3;

  // Fault codes
  typedef logic [1:0] fault_t;

  localparam fault_t FAULT_OK      = 2'd0;
  localparam fault_t FAULT_TERM    = 2'd1;
  localparam fault_t FAULT_ILLEGAL = 2'd2;

  localparam int ID_W    = 6;
  localparam int COUNT_W = 7;
  localparam int FAIL_W  = 16;

  // Input word
  typedef struct packed {
    cmd_code_t         cmd;
    logic [ID_W-1:0]   conn_id;
    logic              ack_flag;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                send_packet;
    logic                packet_ack;
    logic                fail_pending;
    logic                all_closed;
    logic                request_terminate;
    cstate_t             new_state;
    logic [COUNT_W-1:0]  outstanding_count;
    logic [FAIL_W-1:0]   failed_total;
    fault_t              fault;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input word and read the state table
    logic commit;    // apply the transition and load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new word this cycle
  } dp_sts_t;

endpackage

### sv/cchs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchs_ctrl
// Sequencer: accept a word, then commit its transition once the result
// register is free.
// ----------------------------------------------------------------------------
module cchs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cchs_pkg::dp_sts_t sts,
  output cchs_pkg::dp_cmd_t cmd
);

  typedef enum logic {
    C_IDLE,
    C_EXEC
  } ctrl_state_t;

  ctrl_state_t state;

  // Issue commands from the current state
  always_comb begin
    cmd.capture = (state == C_IDLE) && in_valid;
    cmd.commit  = (state == C_EXEC) && sts.out_free;
  end

  // Hold state and the registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        C_IDLE: begin
          if (in_valid) begin
            state    <= C_EXEC;
            in_stall <= 1'b1;
          end
        end
        C_EXEC: begin
          if (sts.out_free) begin
            state    <= C_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= C_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  a_stall_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> in_stall && !cmd.capture)
    else $error("input not stalled while a word is in flight");

  a_stall_tracks_state: assert property (@(posedge clk) disable iff (rst)
    in_stall == (state == C_EXEC))
    else $error("stall out of step with sequencer state");

endmodule

### sv/cchs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchs_dp
// Datapath: per-connection state table, close and failure counters,
// transition logic and the result register.
// ----------------------------------------------------------------------------
module cchs_dp #(
  parameter int NUM_CONN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  cchs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cchs_pkg::out_word_t out_data,
  input  cchs_pkg::dp_cmd_t   cmd,
  output cchs_pkg::dp_sts_t   sts
);

  // Only ids the input field can name need storage
  localparam int MAX_IDS = 1 << cchs_pkg::ID_W;
  localparam int DEPTH   = (NUM_CONN < MAX_IDS) ? NUM_CONN : MAX_IDS;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cchs_pkg::cstate_t            mem [DEPTH];
  logic [DEPTH-1:0]             vld;
  cchs_pkg::in_word_t           in_q;
  cchs_pkg::cstate_t            rd_state;
  logic                         rd_vld;
  logic [cchs_pkg::COUNT_W-1:0] open_closes;
  logic [cchs_pkg::FAIL_W-1:0]  failed_count;

  logic [IDX_W-1:0]             raddr;
  logic [IDX_W-1:0]             waddr;
  logic                         in_range;
  cchs_pkg::cstate_t            cur;
  cchs_pkg::cstate_t            nst;
  cchs_pkg::fault_t             fault;
  logic                         send, pack, failp, term, inc, dec, fail_inc;
  logic [cchs_pkg::COUNT_W-1:0] open_closes_next;
  logic [cchs_pkg::FAIL_W-1:0]  failed_count_next;
  logic                         all_closed;

  assign raddr    = in_data.conn_id[IDX_W-1:0];
  assign waddr    = in_q.conn_id[IDX_W-1:0];
  assign in_range = 32'(in_q.conn_id) < NUM_CONN;
  assign sts.out_free = !out_valid || !out_stall;

  // Current state; never-written entries read as inactive
  assign cur = (in_range && rd_vld) ? rd_state : cchs_pkg::ST_INACTIVE;

  // Transition decode
  always_comb begin
    nst      = cur;
    fault    = cchs_pkg::FAULT_OK;
    send     = 1'b0;
    pack     = 1'b0;
    failp    = 1'b0;
    term     = 1'b0;
    inc      = 1'b0;
    dec      = 1'b0;
    fail_inc = 1'b0;
    if (!in_range) begin
      fault = cchs_pkg::FAULT_ILLEGAL;
    end else begin
      case (in_q.cmd)
        cchs_pkg::CMD_CLOSE: begin
          if (cur == cchs_pkg::ST_ACTIVE || cur == cchs_pkg::ST_REMOTE) begin
            send = 1'b1;
            pack = (cur == cchs_pkg::ST_REMOTE);
            nst  = (cur == cchs_pkg::ST_ACTIVE) ? cchs_pkg::ST_LOCAL
                                                : cchs_pkg::ST_ACKED;
            inc  = 1'b1;
          end else begin
            fault = cchs_pkg::FAULT_ILLEGAL;
          end
        end
        cchs_pkg::CMD_PACKET: begin
          if (!in_q.ack_flag) begin
            if (cur == cchs_pkg::ST_LOCAL) begin
              nst = cchs_pkg::ST_ACKED;
            end else if (cur == cchs_pkg::ST_ACTIVE) begin
              nst = cchs_pkg::ST_REMOTE;
            end else begin
              fault = cchs_pkg::FAULT_ILLEGAL;
            end
          end else begin
            if (cur == cchs_pkg::ST_LOCAL || cur == cchs_pkg::ST_ACKED) begin
              nst  = cchs_pkg::ST_CLOSED;
              term = 1'b1;
            end else begin
              fault = cchs_pkg::FAULT_ILLEGAL;
            end
          end
          // Local close always answers with an ack packet
          if (fault == cchs_pkg::FAULT_OK && cur == cchs_pkg::ST_LOCAL) begin
            send = 1'b1;
            pack = 1'b1;
          end
        end
        cchs_pkg::CMD_TERM: begin
          case (cur)
            cchs_pkg::ST_CLOSED: begin
              nst = cchs_pkg::ST_INACTIVE;
              dec = 1'b1;
            end
            cchs_pkg::ST_INACTIVE, cchs_pkg::ST_ACTIVE, cchs_pkg::ST_REMOTE: begin
              failp    = 1'b1;
              fail_inc = 1'b1;
              nst      = cchs_pkg::ST_MORIBUND;
            end
            cchs_pkg::ST_LOCAL, cchs_pkg::ST_ACKED: begin
              failp    = 1'b1;
              fail_inc = 1'b1;
              nst      = cchs_pkg::ST_MORIBUND;
              dec      = 1'b1;
            end
            default: begin
              fault = cchs_pkg::FAULT_TERM;
            end
          endcase
        end
        cchs_pkg::CMD_ACTIVATE: begin
          if (cur == cchs_pkg::ST_INACTIVE) begin
            nst = cchs_pkg::ST_ACTIVE;
          end else begin
            fault = cchs_pkg::FAULT_ILLEGAL;
          end
        end
        default: begin
          fault = cchs_pkg::FAULT_ILLEGAL;
        end
      endcase
    end
  end

  // Saturating counters
  always_comb begin
    open_closes_next  = open_closes;
    failed_count_next = failed_count;
    if (inc && open_closes != {cchs_pkg::COUNT_W{1'b1}}) begin
      open_closes_next = open_closes + 1'b1;
    end
    if (dec && open_closes != '0) begin
      open_closes_next = open_closes - 1'b1;
    end
    if (fail_inc && failed_count != {cchs_pkg::FAIL_W{1'b1}}) begin
      failed_count_next = failed_count + 1'b1;
    end
  end

  assign all_closed = dec && (open_closes_next == '0);

  // State table: registered read on capture, write on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q     <= in_data;
      rd_state <= mem[raddr];
    end
    if (cmd.commit && fault == cchs_pkg::FAULT_OK) begin
      mem[waddr] <= nst;
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rd_vld <= vld[raddr];
      end
      if (cmd.commit && fault == cchs_pkg::FAULT_OK) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      open_closes  <= '0;
      failed_count <= '0;
    end else if (cmd.commit) begin
      open_closes  <= open_closes_next;
      failed_count <= failed_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.send_packet       <= send;
      out_data.packet_ack        <= pack;
      out_data.fail_pending      <= failp;
      out_data.all_closed        <= all_closed;
      out_data.request_terminate <= term;
      out_data.new_state         <= nst;
      out_data.outstanding_count <= open_closes_next;
      out_data.failed_total      <= failed_count_next;
      out_data.fault             <= fault;
    end
  end

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> failed_count >= $past(failed_count))
    else $error("failed count went down");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && fault != cchs_pkg::FAULT_OK) |=>
      open_closes == $past(open_closes) && failed_count == $past(failed_count))
    else $error("counters moved on a faulted word");

endmodule

### sv/connection_close_handshake_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_close_handshake_fsm
// Close handshake tracker for a set of connections: per-connection state,
// outstanding close count and saturating failure count.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------
//  in      | to block  | in_valid/in_stall  | cchs_pkg::in_word_t
//  out     | from block| out_valid/out_stall| cchs_pkg::out_word_t
//
//  Each word first reads the state table (registered read), then applies
//  the transition and writes back; no new word is taken until the last one
//  has committed. The result register lets the next word enter while a
//  result waits, but a second commit holds until that result is taken.
//  Reset clears all connections to inactive at once through per-entry
//  valid bits, and zeroes both counters.
// ----------------------------------------------------------------------------
module connection_close_handshake_fsm #(
  parameter int NUM_CONN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cchs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cchs_pkg::out_word_t out_data
);

  cchs_pkg::dp_cmd_t cmd;
  cchs_pkg::dp_sts_t sts;

  cchs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cchs_dp #(
    .NUM_CONN (NUM_CONN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### sim/connection_close_handshake_fsm_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_close_handshake_fsm_test
// Self-checking bench for the close handshake tracker. Directed walks cover
// the local, remote and fast close paths and the failure paths. Random
// traffic follows mostly legal handshakes on many connections, with illegal
// commands mixed in. Every result word is checked field by field against a
// local model of the per-connection states and the two counters.
// ----------------------------------------------------------------------------
module connection_close_handshake_fsm_test;

  localparam int CONN_COUNT  = 64;
  localparam int STUCK_LIMIT = 2000;
  // cap on connections deliberately failed by random traffic
  localparam int KILL_BUDGET = 40;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cchs_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cchs_pkg::out_word_t out_data;

  // model state
  cchs_pkg::cstate_t            conn_table [CONN_COUNT];
  logic [cchs_pkg::COUNT_W-1:0] close_backlog = '0;
  logic [cchs_pkg::FAIL_W-1:0]  fail_tally = '0;

  cchs_pkg::out_word_t pending_results [$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        error_count = 0;
  int        sent_count = 0;
  int        checked_count = 0;
  int        stuck_cycles = 0;

  connection_close_handshake_fsm #(.NUM_CONN(CONN_COUNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    for (int i = 0; i < CONN_COUNT; i++) conn_table[i] = cchs_pkg::ST_INACTIVE;
  end

  // Retire one outstanding close; report whether the backlog is now empty
  function automatic logic retire_close();
    if (close_backlog != '0) close_backlog = close_backlog - 1'b1;
    return close_backlog == '0;
  endfunction

  // Apply one word to the model and return the result it must produce
  function automatic cchs_pkg::out_word_t advance_close_fsm(input cchs_pkg::in_word_t w);
    cchs_pkg::out_word_t r;
    cchs_pkg::cstate_t   st;
    cchs_pkg::cstate_t   nst;
    r   = '0;
    st  = conn_table[w.conn_id];
    nst = st;
    case (w.cmd)
      cchs_pkg::CMD_CLOSE: begin
        if (st == cchs_pkg::ST_ACTIVE || st == cchs_pkg::ST_REMOTE) begin
          r.send_packet = 1'b1;
          r.packet_ack  = (st == cchs_pkg::ST_REMOTE);
          nst = (st == cchs_pkg::ST_ACTIVE) ? cchs_pkg::ST_LOCAL : cchs_pkg::ST_ACKED;
          if (close_backlog != 7'd127) close_backlog = close_backlog + 1'b1;
        end else begin
          r.fault = cchs_pkg::FAULT_ILLEGAL;
        end
      end
      cchs_pkg::CMD_PACKET: begin
        if (!w.ack_flag && st == cchs_pkg::ST_LOCAL) nst = cchs_pkg::ST_ACKED;
        else if (!w.ack_flag && st == cchs_pkg::ST_ACTIVE) nst = cchs_pkg::ST_REMOTE;
        else if (w.ack_flag &&
                 (st == cchs_pkg::ST_LOCAL || st == cchs_pkg::ST_ACKED)) begin
          nst = cchs_pkg::ST_CLOSED;
          r.request_terminate = 1'b1;
        end else begin
          r.fault = cchs_pkg::FAULT_ILLEGAL;
        end
        // any legal packet during our own close is always answered with an ack
        if (r.fault == cchs_pkg::FAULT_OK && st == cchs_pkg::ST_LOCAL) begin
          r.send_packet = 1'b1;
          r.packet_ack  = 1'b1;
        end
      end
      cchs_pkg::CMD_TERM: begin
        case (st)
          cchs_pkg::ST_CLOSED: begin
            nst = cchs_pkg::ST_INACTIVE;
            r.all_closed = retire_close();
          end
          cchs_pkg::ST_INACTIVE, cchs_pkg::ST_ACTIVE, cchs_pkg::ST_REMOTE,
          cchs_pkg::ST_LOCAL, cchs_pkg::ST_ACKED: begin
            r.fail_pending = 1'b1;
            if (fail_tally != 16'hFFFF) fail_tally = fail_tally + 1'b1;
            nst = cchs_pkg::ST_MORIBUND;
            if (st == cchs_pkg::ST_LOCAL || st == cchs_pkg::ST_ACKED)
              r.all_closed = retire_close();
          end
          default: r.fault = cchs_pkg::FAULT_TERM;
        endcase
      end
      default: begin
        if (st == cchs_pkg::ST_INACTIVE) nst = cchs_pkg::ST_ACTIVE;
        else r.fault = cchs_pkg::FAULT_ILLEGAL;
      end
    endcase
    if (r.fault == cchs_pkg::FAULT_OK) conn_table[w.conn_id] = nst;
    else nst = st;
    r.new_state         = nst;
    r.outstanding_count = close_backlog;
    r.failed_total      = fail_tally;
    return r;
  endfunction

  // Pick a random word: mostly the next legal handshake step, some noise
  function automatic cchs_pkg::in_word_t pick_random_word();
    cchs_pkg::in_word_t w;
    cchs_pkg::cstate_t  st;
    int                 tries;
    w.ack_flag = 1'($urandom_range(1));
    w.conn_id  = 6'($urandom_range(CONN_COUNT - 1));
    // steer away from dead connections, but not always
    for (tries = 0;
         tries < 3 && conn_table[w.conn_id] == cchs_pkg::ST_MORIBUND;
         tries++)
      w.conn_id = 6'($urandom_range(CONN_COUNT - 1));
    st = conn_table[w.conn_id];
    if ($urandom_range(99) < 80) begin
      case (st)
        cchs_pkg::ST_INACTIVE: w.cmd = cchs_pkg::CMD_ACTIVATE;
        cchs_pkg::ST_ACTIVE: begin
          if ($urandom_range(1) == 0) w.cmd = cchs_pkg::CMD_CLOSE;
          else begin
            w.cmd      = cchs_pkg::CMD_PACKET;
            w.ack_flag = 1'b0;
          end
        end
        cchs_pkg::ST_LOCAL:  w.cmd = cchs_pkg::CMD_PACKET;
        cchs_pkg::ST_REMOTE: w.cmd = cchs_pkg::CMD_CLOSE;
        cchs_pkg::ST_ACKED: begin
          w.cmd      = cchs_pkg::CMD_PACKET;
          w.ack_flag = 1'b1;
        end
        default:   w.cmd = cchs_pkg::CMD_TERM;
      endcase
    end else begin
      w.cmd = cchs_pkg::cmd_code_t'($urandom_range(3));
      // failing a live connection is permanent; ration it
      if (w.cmd == cchs_pkg::CMD_TERM && st != cchs_pkg::ST_CLOSED &&
          st != cchs_pkg::ST_MORIBUND &&
          (fail_tally >= KILL_BUDGET || $urandom_range(3) != 0))
        w.cmd = cchs_pkg::CMD_PACKET;
    end
    return w;
  endfunction

  // Send one word, idling at random first, and record its expected result
  task automatic send_word(input cchs_pkg::in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(advance_close_fsm(w));
    sent_count++;
  endtask

  task automatic send_cmd(input cchs_pkg::cmd_code_t cmd, input int id, input logic ack);
    cchs_pkg::in_word_t w;
    w.cmd      = cmd;
    w.conn_id  = 6'(id);
    w.ack_flag = ack;
    send_word(w);
  endtask

  // Hold the input until every expected result has been taken
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Local close, peer close, peer ack, teardown
  task automatic test_local_close_path();
    send_cmd(cchs_pkg::CMD_ACTIVATE, 63, 1'b1);
    send_cmd(cchs_pkg::CMD_CLOSE, 63, 1'b0);
    send_cmd(cchs_pkg::CMD_CLOSE, 63, 1'b1);
    send_cmd(cchs_pkg::CMD_PACKET, 63, 1'b0);
    send_cmd(cchs_pkg::CMD_PACKET, 63, 1'b0);
    send_cmd(cchs_pkg::CMD_PACKET, 63, 1'b1);
    send_cmd(cchs_pkg::CMD_TERM, 63, 1'b0);
  endtask

  // Peer closes first, we answer with an acked close
  task automatic test_remote_close_path();
    send_cmd(cchs_pkg::CMD_ACTIVATE, 0, 1'b0);
    send_cmd(cchs_pkg::CMD_PACKET, 0, 1'b1);
    send_cmd(cchs_pkg::CMD_PACKET, 0, 1'b0);
    send_cmd(cchs_pkg::CMD_CLOSE, 0, 1'b1);
    send_cmd(cchs_pkg::CMD_PACKET, 0, 1'b1);
    send_cmd(cchs_pkg::CMD_TERM, 0, 1'b1);
  endtask

  // Peer acks our close directly
  task automatic test_fast_close();
    send_cmd(cchs_pkg::CMD_ACTIVATE, 1, 1'b0);
    send_cmd(cchs_pkg::CMD_CLOSE, 1, 1'b0);
    send_cmd(cchs_pkg::CMD_PACKET, 1, 1'b1);
    send_cmd(cchs_pkg::CMD_ACTIVATE, 1, 1'b0);
    send_cmd(cchs_pkg::CMD_TERM, 1, 1'b0);
  endtask

  // Teardown of an idle connection, again once it is dead, then of a closing one
  task automatic test_failure_paths();
    send_cmd(cchs_pkg::CMD_TERM, 62, 1'b0);
    send_cmd(cchs_pkg::CMD_TERM, 62, 1'b1);
    send_cmd(cchs_pkg::CMD_ACTIVATE, 61, 1'b1);
    send_cmd(cchs_pkg::CMD_CLOSE, 61, 1'b0);
    send_cmd(cchs_pkg::CMD_TERM, 61, 1'b0);
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_word(pick_random_word());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_idling(21, 67);
    test_local_close_path();
    test_remote_close_path();
    test_fast_close();
    test_failure_paths();
    test_random_traffic(550);
    wait_for_drain();

    set_idling(67, 21);
    test_random_traffic(550);
    wait_for_drain();

    set_idling(0, 0);
    test_random_traffic(550);
    wait_for_drain();

    repeat (8) @(posedge clk);
    $display("Sent %0d words over three idling mixes; checked %0d results.",
             sent_count, checked_count);
    $display("Connections failed: %0d, closes still outstanding: %0d.",
             fail_tally, close_backlog);
    if (error_count == 0) begin
      $display("connection_close_handshake_fsm verification clean");
    end else begin
      $display("connection_close_handshake_fsm verification failed");
    end
    $finish;
  end

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic note_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Check result words; sample mid-cycle so the accepting edge is unambiguous
  always @(negedge clk) begin
    cchs_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        note_field("send_packet", want.send_packet, out_data.send_packet);
        note_field("packet_ack", want.packet_ack, out_data.packet_ack);
        note_field("fail_pending", want.fail_pending, out_data.fail_pending);
        note_field("all_closed", want.all_closed, out_data.all_closed);
        note_field("request_terminate", want.request_terminate,
                   out_data.request_terminate);
        note_field("new_state", want.new_state, out_data.new_state);
        note_field("outstanding_count", want.outstanding_count,
                   out_data.outstanding_count);
        note_field("failed_total", want.failed_total, out_data.failed_total);
        note_field("fault", want.fault, out_data.fault);
        checked_count++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("connection_close_handshake_fsm verification failed");
        $finish;
      end
    end
  end

endmodule
